[hdl/qcsv_pkg.sv]
// Shared types, constants and helpers for the quoted CSV field splitter.
`default_nettype none

package qcsv_pkg;

    localparam logic [7:0] LINE_END      = 8'h0A;
    localparam logic [7:0] SEP_RESET     = 8'h2C;
    localparam logic [7:0] QUOTE_RESET   = 8'h22;
    localparam int         CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 1'd1;

    typedef enum logic [1:0] {
        TK_CHAR       = 2'd0,
        TK_FIELD_END  = 2'd1,
        TK_RECORD_END = 2'd2,
        TK_STOP       = 2'd3
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  char_value;
        logic        last;
    } result_t;

    // Results produced by one item: zero, one or two.
    typedef struct packed {
        logic [1:0]       count;
        result_t [1:0]    res;
    } push_t;

    function automatic logic [1:0] pos_advance(input logic [1:0] pos);
        begin
            pos_advance = (pos == 2'd3) ? pos : pos + 2'd1;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/quoted_csv_field_splitter.sv]
// Top level of the quoted CSV field splitter: configuration registers and wiring.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall  | data_byte, end_of_input
//   output  | out       | out_valid / out_stall| token_kind, char_value, last_of_run
//   config  | in        | cfg_write_en         | cfg_index, cfg_data
//
// An item is registered on entry and decided from that register; its results are
// written into the result queue, which drives the output. Each item yields zero to
// two results, and the output port sends one result per cycle while out_stall is low:
// the sustained rate is one item per cycle while items yield at most one result each
// and the receiver does not stall, and the two results of an item leave the output
// one after the other. The four-entry result queue absorbs output stalls; the input
// stalls when it cannot hold another pair. Reset clears the tokenizer state and loads
// comma and double quote.
`default_nettype none

module quoted_csv_field_splitter
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            end_of_input,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           token_kind,
    output logic [7:0]                           char_value,
    output logic                                 last_of_run,
    input  wire logic                            cfg_write_en,
    input  wire logic [qcsv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import qcsv_pkg::*;

    logic [7:0] separator_reg;
    logic [7:0] quote_reg;
    logic       room;
    push_t      push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEP_RESET;
            quote_reg     <= QUOTE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SEPARATOR: separator_reg <= cfg_data;
                REG_QUOTE:     quote_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    qcsv_step u_step
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_input   (end_of_input),
        .separator_char (separator_reg),
        .quote_char     (quote_reg),
        .room           (room),
        .push           (push)
    );

    qcsv_out u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .char_value  (char_value),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[hdl/qcsv_step.sv]
// Input register, tokenizer state and the per-item decision logic.
`default_nettype none

module qcsv_step
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_input,
    input  wire logic [7:0]       separator_char,
    input  wire logic [7:0]       quote_char,
    input  wire logic             room,
    output qcsv_pkg::push_t       push
);
    import qcsv_pkg::*;

    logic       item_valid_reg;
    logic [7:0] byte_reg;
    logic       eoi_reg;

    logic       inside_quotes_reg, inside_quotes_next;
    logic       quote_pending_reg, quote_pending_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [1:0] line_position_reg, line_position_next;
    logic       record_open_reg, record_open_next;
    logic       stopped_reg, stopped_next;

    logic       fire;
    logic [1:0] n;
    result_t    res [2];
    logic       done;

    assign fire     = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;

    always_comb
    begin
        inside_quotes_next = inside_quotes_reg;
        quote_pending_next = quote_pending_reg;
        previous_byte_next = previous_byte_reg;
        line_position_next = line_position_reg;
        record_open_next   = record_open_reg;
        stopped_next       = stopped_reg;
        n    = 2'd0;
        done = 1'b0;
        res[0] = '{kind: TK_STOP, char_value: 8'h00, last: 1'b0};
        res[1] = '{kind: TK_STOP, char_value: 8'h00, last: 1'b0};

        if (stopped_reg)
        begin
            res[0] = '{kind: TK_STOP, char_value: 8'h00, last: 1'b0};
            n = 2'd1;
        end
        else if (eoi_reg)
        begin
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                inside_quotes_next = !inside_quotes_reg;
                line_position_next = pos_advance(line_position_reg);
                previous_byte_next = quote_char;
            end
            if (record_open_reg)
            begin
                res[n[0]] = '{kind: TK_RECORD_END, char_value: 8'h00, last: 1'b0};
                n = n + 2'd1;
                record_open_next = 1'b0;
            end
            res[n[0]] = '{kind: TK_STOP, char_value: 8'h00, last: 1'b0};
            n = n + 2'd1;
            stopped_next = 1'b1;
        end
        else
        begin
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (inside_quotes_reg && byte_reg == quote_char && byte_reg != LINE_END)
                begin
                    // Doubled quote inside quotes stands for one quote.
                    res[0] = '{kind: TK_CHAR, char_value: quote_char, last: 1'b0};
                    n = 2'd1;
                    line_position_next = pos_advance(pos_advance(line_position_reg));
                    previous_byte_next = quote_char;
                    done = 1'b1;
                end
                else
                begin
                    inside_quotes_next = !inside_quotes_reg;
                    // A quote in mid-field keeps its character as data as well.
                    if (line_position_reg == 2'd3 && previous_byte_reg != separator_char &&
                        byte_reg != LINE_END && byte_reg != separator_char)
                    begin
                        res[0] = '{kind: TK_CHAR, char_value: quote_char, last: 1'b0};
                        n = 2'd1;
                    end
                    line_position_next = pos_advance(line_position_reg);
                    previous_byte_next = quote_char;
                end
            end

            if (!done && !record_open_reg)
            begin
                if (byte_reg == LINE_END)
                begin
                    stopped_next = 1'b1;
                    res[n[0]] = '{kind: TK_STOP, char_value: 8'h00, last: 1'b0};
                    n = n + 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    record_open_next = 1'b1;
                end
            end

            if (!done)
            begin
                if (byte_reg == LINE_END)
                begin
                    if (inside_quotes_next)
                    begin
                        res[n[0]] = '{kind: TK_CHAR, char_value: LINE_END, last: 1'b0};
                    end
                    else
                    begin
                        res[n[0]] = '{kind: TK_RECORD_END, char_value: 8'h00, last: 1'b0};
                        record_open_next = 1'b0;
                    end
                    n = n + 2'd1;
                    line_position_next = 2'd0;
                    previous_byte_next = 8'h00;
                end
                else if (byte_reg == quote_char)
                begin
                    quote_pending_next = 1'b1;
                end
                else if (byte_reg == separator_char && !inside_quotes_next)
                begin
                    res[n[0]] = '{kind: TK_FIELD_END, char_value: 8'h00, last: 1'b0};
                    n = n + 2'd1;
                    line_position_next = pos_advance(line_position_next);
                    previous_byte_next = byte_reg;
                end
                else
                begin
                    res[n[0]] = '{kind: TK_CHAR, char_value: byte_reg, last: 1'b0};
                    n = n + 2'd1;
                    line_position_next = pos_advance(line_position_next);
                    previous_byte_next = byte_reg;
                end
            end
        end

        if (n == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res[1].last = 1'b1;
        end

        push.count = fire ? n : 2'd0;
        push.res   = {res[1], res[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            inside_quotes_reg <= 1'b0;
            quote_pending_reg <= 1'b0;
            previous_byte_reg <= 8'h00;
            line_position_reg <= 2'd0;
            record_open_reg   <= 1'b0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                item_valid_reg <= in_valid;
            end
            if (fire)
            begin
                inside_quotes_reg <= inside_quotes_next;
                quote_pending_reg <= quote_pending_next;
                previous_byte_reg <= previous_byte_next;
                line_position_reg <= line_position_next;
                record_open_reg   <= record_open_next;
                stopped_reg       <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
    end

endmodule

`default_nettype wire

[hdl/qcsv_out.sv]
// Four-entry result queue that takes up to two results per cycle and sends one while out_stall is low.
`default_nettype none

module qcsv_out
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qcsv_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             token_kind,
    output logic [7:0]             char_value,
    output logic                   last_of_run
);
    import qcsv_pkg::*;

    result_t    fifo_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;
    result_t    head;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != 3'd0);
    // Room for a full pair of results, judged before this cycle's pop.
    assign room      = (count_reg <= 3'd2);

    assign head        = fifo_reg[rd_ptr_reg];
    assign token_kind  = head.kind;
    assign char_value  = head.char_value;
    assign last_of_run = head.last;

    assign count_next = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push.res[0];
        end
        if (push.count == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= push.res[1];
        end
    end

endmodule

`default_nettype wire

[test/quoted_csv_field_splitter_tb.sv]
// Self-checking testbench for the quoted CSV field splitter, driven by directed and random CSV text.
module quoted_csv_field_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qcsv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 12;
    localparam logic [7:0] SEP_TABLE [6] = '{SEP_RESET, 8'h09, 8'h00, 8'hFF, 8'h3B, 8'h7C};
    localparam logic [7:0] QUOTE_TABLE [6] = '{QUOTE_RESET, 8'h27, 8'hFF, 8'h00, LINE_END, 8'h7C};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'h00;
    logic end_of_input = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] token_kind;
    logic [7:0] char_value;
    logic last_of_run;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SEPARATOR;
    logic [7:0] cfg_data = 8'h00;

    // Shadow of the tokenizer: configuration and state after every accepted item.
    logic [7:0] sep_reg = SEP_RESET;
    logic [7:0] quote_reg = QUOTE_RESET;
    logic in_quotes = 1'b0;
    logic quote_held = 1'b0;
    logic [7:0] prev_byte = 8'h00;
    logic [1:0] line_pos = 2'd0;
    logic rec_open = 1'b0;
    logic stopped = 1'b0;

    result_t token_queue[$];
    int mismatches = 0;
    int cycle_count = 0;
    int hold_left = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    quoted_csv_field_splitter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .char_value   (char_value),
        .last_of_run  (last_of_run),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold-off, counted down here once a test arms it.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d char %02h last %0b",
                             token_kind, char_value, last_of_run);
            end
            else
            begin
                want = token_queue.pop_front();
                if (token_kind !== want.kind || char_value !== want.char_value ||
                    last_of_run !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"token mismatch: expected kind %0d char %02h last %0b,",
                                  " got %0d %02h %0b"},
                                 want.kind, want.char_value, want.last,
                                 token_kind, char_value, last_of_run);
                end
            end
        end
        out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [1:0] bump_pos(input logic [1:0] p);
        return (p == 2'd3) ? p : p + 2'd1;
    endfunction

    function automatic result_t token(input token_kind_t k, input logic [7:0] c);
        return '{kind: k, char_value: c, last: 1'b0};
    endfunction

    // Works out the tokens that one accepted item produces and queues them.
    task automatic tokenize(input logic [7:0] b, input logic eoi);
        result_t toks[$];
        logic done;
        done = 1'b0;
        if (stopped)
            toks = {toks, token(TK_STOP, 8'h00)};
        else if (eoi)
        begin
            // A quote still held at end of input toggles the quote state and yields no character.
            if (quote_held)
            begin
                quote_held = 1'b0;
                in_quotes = !in_quotes;
                line_pos = bump_pos(line_pos);
                prev_byte = quote_reg;
            end
            if (rec_open)
            begin
                toks = {toks, token(TK_RECORD_END, 8'h00)};
                rec_open = 1'b0;
            end
            toks = {toks, token(TK_STOP, 8'h00)};
            stopped = 1'b1;
        end
        else
        begin
            if (quote_held)
            begin
                quote_held = 1'b0;
                if (in_quotes && b == quote_reg && b != LINE_END)
                begin
                    toks = {toks, token(TK_CHAR, quote_reg)};
                    line_pos = bump_pos(bump_pos(line_pos));
                    prev_byte = quote_reg;
                    done = 1'b1;
                end
                else
                begin
                    in_quotes = !in_quotes;
                    if (line_pos == 2'd3 && prev_byte != sep_reg && b != LINE_END &&
                        b != sep_reg)
                        toks = {toks, token(TK_CHAR, quote_reg)};
                    line_pos = bump_pos(line_pos);
                    prev_byte = quote_reg;
                end
            end
            if (!done && !rec_open)
            begin
                if (b == LINE_END)
                begin
                    stopped = 1'b1;
                    toks = {toks, token(TK_STOP, 8'h00)};
                    done = 1'b1;
                end
                else
                    rec_open = 1'b1;
            end
            if (!done)
            begin
                if (b == LINE_END)
                begin
                    if (in_quotes)
                        toks = {toks, token(TK_CHAR, LINE_END)};
                    else
                    begin
                        toks = {toks, token(TK_RECORD_END, 8'h00)};
                        rec_open = 1'b0;
                    end
                    line_pos = 2'd0;
                    prev_byte = 8'h00;
                end
                else if (b == quote_reg)
                    quote_held = 1'b1;
                else
                begin
                    if (b == sep_reg && !in_quotes)
                        toks = {toks, token(TK_FIELD_END, 8'h00)};
                    else
                        toks = {toks, token(TK_CHAR, b)};
                    line_pos = bump_pos(line_pos);
                    prev_byte = b;
                end
            end
        end
        if (toks.size() > 0)
            toks[toks.size() - 1].last = 1'b1;
        token_queue = {token_queue, toks};
    endtask

    task automatic send_item(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (in_stall);
        tokenize(b, eoi);
        items_sent++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == sep_reg || c == quote_reg || c == LINE_END);
        return c;
    endfunction

    // A newline with no record open would stop the stream, so it is swapped for a character.
    task automatic send_byte(input logic [7:0] b);
        if (!rec_open && !stopped && b == LINE_END)
            b = plain_char();
        send_item(b, 1'b0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
            default: begin send_gap_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    task automatic configure(input logic [7:0] sep, input logic [7:0] quo);
        // Resolve a held quote before the quote byte changes under it.
        if (quote_held && !stopped)
            send_byte(plain_char());
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_index <= REG_SEPARATOR;
        cfg_data <= sep;
        @(posedge clk);
        cfg_index <= REG_QUOTE;
        cfg_data <= quo;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sep_reg = sep;
        quote_reg = quo;
    endtask

    // One CSV record with plain, quoted and empty fields, ending in a newline.
    task automatic send_record();
        logic [7:0] text[$];
        int nf;
        int len;
        int pick;
        int at;
        nf = $urandom_range(4, 1);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                text = {text, sep_reg};
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                text = {text, quote_reg};
                len = $urandom_range(5);
                for (int j = 0; j < len; j++)
                begin
                    at = $urandom_range(9);
                    if (at == 0)
                        text = {text, sep_reg};
                    else if (at == 1)
                        text = {text, LINE_END};
                    else if (at == 2)
                        text = {text, quote_reg, quote_reg};
                    else
                        text = {text, plain_char()};
                end
                text = {text, quote_reg};
            end
            else if (pick < 90)
            begin
                len = $urandom_range(6);
                // Sometimes a stray quote lands inside an unquoted field.
                at = ($urandom_range(99) < 25) ? $urandom_range(len) : -1;
                for (int j = 0; j <= len; j++)
                begin
                    if (j == at)
                        text = {text, quote_reg};
                    if (j < len)
                        text = {text, plain_char()};
                end
            end
        end
        text = {text, LINE_END};
        foreach (text[i])
            send_byte(text[i]);
    endtask

    task automatic test_directed();
        string text;
        text = "a,b\n\"x,\n\"\"y\",abc\"d\n\"\n";
        set_idling(0);
        for (int k = 0; k < text.len(); k++)
            send_byte(text[k]);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(LINE_END);
    endtask

    task automatic test_random_text(input int phase);
        int start;
        configure(SEP_TABLE[phase], QUOTE_TABLE[phase]);
        set_idling(phase % 4);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 85)
                send_record();
            else
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // The receiver holds off while the sender keeps offering items, so the block fills up.
    task automatic test_backpressure();
        wait_idle();
        set_idling(0);
        @(posedge clk);
        hold_left <= HOLD_CYCLES;
        for (int k = 0; k < 40; k++)
            send_byte((k % 5 == 4) ? sep_reg : plain_char());
        wait_idle();
    endtask

    // Stops the stream by end of input or by an empty line, then sends a few more items.
    task automatic test_stop();
        set_idling(3);
        if ($urandom_range(1))
        begin
            send_item(quote_reg, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
        end
        else
        begin
            for (int k = 0; k < 6 && !stopped; k++)
            begin
                if (in_quotes && !quote_held)
                    send_item(quote_reg, 1'b0);
                else
                    send_item(LINE_END, 1'b0);
            end
        end
        repeat (3) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        for (int p = 0; p < 6; p++)
        begin
            test_random_text(p);
            if (p == 2)
                test_backpressure();
        end
        test_stop();
        in_valid <= 1'b0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && token_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/qcsv_pkg.sv
hdl/qcsv_step.sv
hdl/qcsv_out.sv
hdl/quoted_csv_field_splitter.sv
test/quoted_csv_field_splitter_tb.sv
